FILE: sv/wrm_pkg.sv
// Shared constants, codes and control structures of the wildcard matcher.
package wrm_pkg;

	localparam int MAX_PATTERN = 32;

	localparam logic [7:0] STAR_CH = 8'h2A;
	localparam logic [7:0] DOT_CH  = 8'h2E;

	typedef enum logic [1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_TEXT   = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic append;
		logic clear;
		logic query;
		logic text_empty;
		logic text_start;
		logic fetch;
		logic step;
		logic emit;
		logic last;
	} wrm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic len_zero;
		logic done;
		logic out_free;
	} wrm_stat_t;

endpackage

FILE: sv/wrm_datapath.sv
// Datapath: pattern memory, match rows, position sweep and result register.
module wrm_datapath #(
	parameter int MaxPattern = wrm_pkg::MAX_PATTERN
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wrm_pkg::wrm_cmd_t cmd,
	input  logic [7:0]        symbol,
	output wrm_pkg::wrm_stat_t stat,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata
);
	import wrm_pkg::*;

	localparam int LW = $clog2(MaxPattern + 1);
	localparam int IW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
	localparam int RW = MaxPattern + 1;

	logic [7:0]    pat_mem [MaxPattern];
	logic [7:0]    rd_q;
	logic [IW-1:0] rd_addr;

	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic [RW-1:0] etr_q;
	logic [RW-1:0] cur_q;
	logic [RW-1:0] nr_q;
	logic [RW-1:0] old_sh_q;
	logic [IW-1:0] idx_q;
	logic [7:0]    prev_pc_q;
	logic [7:0]    sym_q;
	logic          v1_q;
	logic          v2_q;
	logic          out_valid_q;
	logic [1:0]    out_data_q;

	logic          full;
	logic [LW-1:0] j_idx;
	logic          hit;
	logic          prev_hit;
	logic          v;
	logic [RW-1:0] nr_next;
	logic          etr_bit;
	logic [RW-1:0] etr_next;
	logic          out_free;
	logic          out_load;
	logic [1:0]    out_next;

	assign full     = (len_q == LW'(MaxPattern));
	assign j_idx    = LW'(idx_q) + LW'(1);
	assign hit      = (rd_q == DOT_CH) || (rd_q == sym_q);
	assign prev_hit = (prev_pc_q == DOT_CH) || (prev_pc_q == sym_q);

	always_comb begin
		if (rd_q == STAR_CH) begin
			v = (idx_q != '0) && (v2_q || (prev_hit && old_sh_q[1]));
		end else begin
			v = hit && old_sh_q[0];
		end
	end

	assign nr_next = nr_q | (RW'(v) << j_idx);

	assign etr_bit  = (symbol == STAR_CH) && (len_q != '0) && etr_q[len_q - LW'(1)];
	assign etr_next = etr_q | (RW'(etr_bit) << (len_q + LW'(1)));

	assign rd_addr = cmd.fetch ? idx_q : idx_q + IW'(1);

	// Pattern memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			pat_mem[len_q[IW-1:0]] <= symbol;
		end
		if (32'(rd_addr) < MaxPattern) begin
			rd_q <= pat_mem[rd_addr];
		end
	end

	// Sweep registers.
	always_ff @(posedge clk) begin
		if (cmd.text_start) begin
			sym_q    <= symbol;
			old_sh_q <= cur_q;
			nr_q     <= '0;
			idx_q    <= '0;
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
		end else if (cmd.step) begin
			old_sh_q  <= old_sh_q >> 1;
			nr_q      <= nr_next;
			idx_q     <= idx_q + IW'(1);
			prev_pc_q <= rd_q;
			v1_q      <= v;
			v2_q      <= v1_q;
		end
	end

	always_comb begin
		out_load = 1'b0;
		out_next = {ovf_q, 1'b0};
		if (cmd.query) begin
			out_load = 1'b1;
			out_next = {ovf_q, etr_q[len_q] & ~ovf_q};
		end else if (cmd.emit) begin
			out_load = 1'b1;
			out_next = {ovf_q, cur_q[len_q] & ~ovf_q};
		end else if (cmd.text_empty && cmd.last) begin
			out_load = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			etr_q       <= RW'(1);
			cur_q       <= RW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				len_q <= '0;
				ovf_q <= 1'b0;
				etr_q <= RW'(1);
				cur_q <= RW'(1);
			end else if (cmd.append) begin
				if (!full) begin
					len_q <= len_q + LW'(1);
					etr_q <= etr_next;
					cur_q <= etr_next;
				end else begin
					ovf_q <= 1'b1;
					cur_q <= etr_q;
				end
			end else if (cmd.query || cmd.emit) begin
				cur_q <= etr_q;
			end else if (cmd.text_empty) begin
				cur_q <= cmd.last ? etr_q : '0;
			end else if (cmd.step && (j_idx == len_q)) begin
				cur_q <= nr_next;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_next;
		end
	end

	assign out_free      = !out_valid_q || m_tready;
	assign stat.len_zero = (len_q == '0);
	assign stat.done     = (j_idx == len_q);
	assign stat.out_free = out_free;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = {6'b0, out_data_q};

endmodule

FILE: sv/wrm_ctrl.sv
// Controller state machine: decodes transfers and sequences the row sweep.
module wrm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [1:0]         func,
	input  logic               last,
	input  wrm_pkg::wrm_stat_t stat,
	output wrm_pkg::wrm_cmd_t  cmd
);
	import wrm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_SWEEP = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   last_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd      = '0;
		cmd.last = last;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func_t'(func))
						FUNC_APPEND: cmd.append = 1'b1;
						FUNC_QUERY:  cmd.query  = 1'b1;
						FUNC_CLEAR:  cmd.clear  = 1'b1;
						FUNC_TEXT: begin
							if (stat.len_zero) begin
								cmd.text_empty = 1'b1;
							end else begin
								cmd.text_start = 1'b1;
								state_d        = ST_FETCH;
							end
						end
						default: cmd.clear = 1'b1;
					endcase
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_SWEEP;
			end
			ST_SWEEP: begin
				cmd.step = 1'b1;
				if (stat.done) begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.text_start) begin
				last_q <= last;
			end
		end
	end

endmodule

FILE: sv/wildcard_regex_matcher_unit.sv
// Top level of the wildcard matcher: controller and datapath.
//
//  Group  Dir  Fields (lowest bit first)
//  s_*    in   tdata: func[1:0], symbol[9:2], zero fill; tlast: last
//  m_*    out  tdata: matched[0], overflow[1], zero fill
//
// Append, clear and empty-text query are each handled in the cycle of their
// transfer, as is a text byte while the pattern is empty. A text byte against a
// pattern of length L takes one fetch, then one pattern position per cycle
// through the single read port of the pattern memory, then an emit once the
// output register is free if it is the last byte. Reset clears the pattern,
// both rows and the overflow flag; the pattern memory itself needs no clearing.
// A stalled result holds in the output register and holds off every further transfer until it leaves.
module wildcard_regex_matcher_unit #(
	parameter int MaxPattern = wrm_pkg::MAX_PATTERN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // func[1:0], symbol[9:2], zeros above
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // matched[0], overflow[1], zeros above
);
	import wrm_pkg::*;

	wrm_cmd_t  cmd;
	wrm_stat_t stat;

	// Controller: decode each transfer, step the sweep, wait for a free
	// output register before emitting.
	wrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tdata[1:0]),
		.last     (s_tlast),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: hold the pattern and rows, advance one position per step.
	wrm_datapath #(
		.MaxPattern (MaxPattern)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.symbol   (s_tdata[9:2]),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// A sweep always starts with a fetch, and a fetch feeds a step.
	a_start_fetch : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.text_start |=> cmd.fetch)
		else $error("sweep start not followed by fetch");

	a_fetch_step : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |=> cmd.step)
		else $error("fetch not followed by sweep step");

	// Never overwrite a result that is still waiting.
	a_no_overwrite : assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.query) |-> stat.out_free)
		else $error("result loaded while output register busy");

	// No new transfer is taken while a sweep is running.
	a_busy_sweep : assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.fetch) |-> !s_tready)
		else $error("input ready during sweep");

endmodule
